// ===== rtl/teq_pkg.sv =====
package teq_pkg;

    // Width of the millisecond counter and of every due time
    localparam int TIME_W = 32;

    // Fixed widths of the item fields
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int OTAG_W   = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_POST     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISPATCH = 2'd2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_POSTED = 3'd0,
        ST_FULL   = 3'd1,
        ST_FIRED  = 3'd2,
        ST_NONE   = 3'd3,
        ST_TICK   = 3'd4
    } status_t;

endpackage

// ===== rtl/timed_event_queue_top.sv =====
// Timed event queue: a table of NUM_SLOTS timed events plus a 32-bit
// millisecond counter. Every accepted item gives exactly one result item.
// A post (req_type 0) stores the tag in the lowest free slot, due at now
// plus delay (saturating), or reports the table full; a tick (1) advances
// the counter, wrapping at the top; a dispatch (2) fires and frees the
// earliest due event, lowest slot on a tie, if it is not later than now,
// else reports none ready; code 3 reports none ready and changes nothing.
// Post, tick and code 3 go from acceptance to the wait state; a dispatch
// first passes the scan state, where the search for the earliest event
// ripples one slot per cycle along the chain of slot cells, and the decide
// state. One item is worked on at a time, but a new item is taken while the
// previous result still waits in the output register.
module timed_event_queue_top #(
    parameter int NUM_SLOTS = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_delay,
    input  logic [15:0] s_tag,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_fired_tag
);
    import teq_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);

    // one-hot sequencer
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_WAIT   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    status_t            res_status_reg, res_status_next;
    logic [OTAG_W-1:0]  res_tag_reg, res_tag_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [OTAG_W-1:0]  m_tag_reg, m_tag_next;

    // chain of slot cells; index k is the carry entering cell k
    logic [NUM_SLOTS:0] c_found;
    logic [TIME_W-1:0]  c_due [NUM_SLOTS+1];
    logic [TAG_BITS-1:0] c_tag [NUM_SLOTS+1];
    logic [IDX_W-1:0]   c_idx [NUM_SLOTS+1];

    logic [NUM_SLOTS-1:0] valid_vec;
    logic [NUM_SLOTS-1:0] free_oh;
    logic [NUM_SLOTS-1:0] wr_vec;
    logic                 accept;
    logic [TIME_W:0]      due_sum;
    logic [TIME_W-1:0]    due_sat;
    logic [TAG_BITS-1:0]  tag_in;
    logic                 fire;
    logic                 clr_en;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    // lowest clear bit of the valid vector, as a one-hot; zero when full
    assign free_oh = ~valid_vec & (valid_vec + NUM_SLOTS'(1));
    assign wr_vec  = (accept && (s_req_type == REQ_POST)) ? free_oh : '0;

    // due time, saturated at the top of the counter range
    assign due_sum = {1'b0, time_reg} + {1'b0, s_delay};
    assign due_sat = due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];
    assign tag_in  = TAG_BITS'(s_tag);

    // the last carry holds the earliest event once the scan has run through
    assign fire   = c_found[NUM_SLOTS] && (c_due[NUM_SLOTS] <= time_reg);
    assign clr_en = (state_reg == S_DECIDE) && fire;

    assign c_found[0] = 1'b0;
    assign c_due[0]   = '0;
    assign c_tag[0]   = '0;
    assign c_idx[0]   = '0;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        teq_cell #(
            .TAG_BITS (TAG_BITS),
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (wr_vec[k]),
            .wr_due  (due_sat),
            .wr_tag  (tag_in),
            .clr_en  (clr_en),
            .clr_idx (c_idx[NUM_SLOTS]),
            .valid_o (valid_vec[k]),
            .found_i (c_found[k]),
            .due_i   (c_due[k]),
            .tag_i   (c_tag[k]),
            .idx_i   (c_idx[k]),
            .found_o (c_found[k+1]),
            .due_o   (c_due[k+1]),
            .tag_o   (c_tag[k+1]),
            .idx_o   (c_idx[k+1])
        );
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        time_next       = time_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_tag_next      = m_tag_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_tag_next = '0;
                    state_next   = S_WAIT;
                    case (s_req_type)
                        REQ_POST: begin
                            res_status_next = (&valid_vec) ? ST_FULL : ST_POSTED;
                        end
                        REQ_TICK: begin
                            time_next       = time_reg + TIME_W'(1);
                            res_status_next = ST_TICK;
                        end
                        REQ_DISPATCH: begin
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            res_status_next = ST_NONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(NUM_SLOTS - 1)) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                res_status_next = fire ? ST_FIRED : ST_NONE;
                res_tag_next    = fire ? OTAG_W'(c_tag[NUM_SLOTS]) : '0;
                state_next      = S_WAIT;
            end
            S_WAIT: begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_tag_next    = res_tag_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            time_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            time_reg    <= time_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        m_status_reg   <= m_status_next;
        m_tag_reg      <= m_tag_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_fired_tag = m_tag_reg;

endmodule

// ===== rtl/teq_cell.sv =====
module teq_cell #(
    parameter int TAG_BITS = 16,
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // slot update
    input  logic                       wr_en,
    input  logic [teq_pkg::TIME_W-1:0] wr_due,
    input  logic [TAG_BITS-1:0]        wr_tag,
    input  logic                       clr_en,
    input  logic [IDX_W-1:0]           clr_idx,
    output logic                       valid_o,
    // running earliest-event carry from the left neighbour
    input  logic                       found_i,
    input  logic [teq_pkg::TIME_W-1:0] due_i,
    input  logic [TAG_BITS-1:0]        tag_i,
    input  logic [IDX_W-1:0]           idx_i,
    // carry handed on to the right neighbour
    output logic                       found_o,
    output logic [teq_pkg::TIME_W-1:0] due_o,
    output logic [TAG_BITS-1:0]        tag_o,
    output logic [IDX_W-1:0]           idx_o
);
    import teq_pkg::*;

    logic                valid_reg;
    logic [TIME_W-1:0]   due_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic                found_reg;
    logic [TIME_W-1:0]   cdue_reg;
    logic [TAG_BITS-1:0] ctag_reg;
    logic [IDX_W-1:0]    cidx_reg;

    logic take;

    // strictly earlier wins, so the lower slot keeps a tie
    assign take = valid_reg && (!found_i || (due_reg < due_i));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg <= 1'b1;
            end else if (clr_en && (clr_idx == IDX_W'(CELL_IDX))) begin
                valid_reg <= 1'b0;
            end
            found_reg <= found_i || valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            due_reg <= wr_due;
            tag_reg <= wr_tag;
        end
        if (take) begin
            cdue_reg <= due_reg;
            ctag_reg <= tag_reg;
            cidx_reg <= IDX_W'(CELL_IDX);
        end else begin
            cdue_reg <= due_i;
            ctag_reg <= tag_i;
            cidx_reg <= idx_i;
        end
    end

    assign valid_o = valid_reg;
    assign found_o = found_reg;
    assign due_o   = cdue_reg;
    assign tag_o   = ctag_reg;
    assign idx_o   = cidx_reg;

endmodule

// ===== verif/timed_event_queue_top_tb.sv =====
`timescale 1ns / 100ps

module timed_event_queue_top_tb;
    import teq_pkg::*;

    localparam int NUM_SLOTS = 32;
    localparam int TAG_BITS  = 16;

    // Stimulus volume: items wanted in all, and the tail of the run kept free
    // of idling on both sides
    localparam int ITEMS = 650;
    localparam int TAIL  = 80;

    // Long receiver hold-off, started once enough items have gone in
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_LEN   = 400;

    // Worst case is roughly 700 items, each a full dispatch scan with the longest
    // idle gap on each side, plus the long hold; several times over
    localparam int CYCLE_LIMIT = 400000;

    // Request code that the block does not use
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    // What the sender queue holds: an item, an idle gap, or a pause until
    // every outstanding result has come back
    typedef enum logic [1:0] {
        ENTRY_ITEM,
        ENTRY_GAP,
        ENTRY_DRAIN
    } entry_kind_t;

    typedef struct {
        entry_kind_t      kind;
        logic [REQ_W-1:0] req;
        logic [31:0]      delay;
        logic [15:0]      tag;
        int               gap_len;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] fired_tag;
    } result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type  = '0;
    logic [31:0] s_delay     = '0;
    logic [15:0] s_tag       = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_fired_tag;

    // Predicted copy of the event table and the millisecond counter
    logic        slot_busy [NUM_SLOTS];
    logic [31:0] slot_due  [NUM_SLOTS];
    logic [15:0] slot_id   [NUM_SLOTS];
    logic [31:0] now_ms;

    request_t pending [$];
    result_t  expected_results [$];

    // Items accepted but not yet answered; updated on the clock edge so that
    // both the sender and the end of the run read a settled value
    int in_flight  = 0;
    int n_accepted = 0;
    int errors     = 0;
    int cycle_count = 0;

    int tx_gap      = 0;
    bit tx_done     = 1'b0;
    bit tail_part   = 1'b0;

    int rx_gap      = 0;
    int rx_quiet    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    // Stimulus build state
    int n_items     = 0;
    bit tx_gaps_on  = 1'b1;

    timed_event_queue_top #(
        .NUM_SLOTS (NUM_SLOTS),
        .TAG_BITS  (TAG_BITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_delay     (s_delay),
        .s_tag       (s_tag),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_fired_tag (m_fired_tag)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one request to the table copy and returns the
    // single result it gives.
    // ------------------------------------------------------------------
    function automatic result_t event_table_step(input logic [REQ_W-1:0] req,
                                                 input logic [31:0] dly,
                                                 input logic [15:0] id);
        result_t     res;
        int          i;
        int          pick;
        logic [32:0] sum;
        logic [15:0] id_mask;
        res.status    = ST_NONE;
        res.fired_tag = '0;
        id_mask       = (TAG_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << TAG_BITS) - 1);
        case (req)
            REQ_POST: begin
                // lowest free slot
                pick = -1;
                for (i = NUM_SLOTS - 1; i >= 0; i--) begin
                    if (!slot_busy[i]) pick = i;
                end
                if (pick < 0) begin
                    res.status = ST_FULL;
                end else begin
                    // due time saturates at the top of the counter range
                    sum = {1'b0, now_ms} + {1'b0, dly};
                    slot_busy[pick] = 1'b1;
                    slot_due[pick]  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    slot_id[pick]   = id & id_mask;
                    res.status      = ST_POSTED;
                end
            end
            REQ_TICK: begin
                now_ms     = now_ms + 32'd1;
                res.status = ST_TICK;
            end
            REQ_DISPATCH: begin
                // earliest due time, strict compare keeps the lowest slot on a tie
                pick = -1;
                for (i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_busy[i] && (pick < 0 || slot_due[i] < slot_due[pick]))
                        pick = i;
                end
                if (pick >= 0 && slot_due[pick] <= now_ms) begin
                    slot_busy[pick] = 1'b0;
                    res.status      = ST_FIRED;
                    res.fired_tag   = slot_id[pick];
                end
            end
            default: res.status = ST_NONE;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic [REQ_W-1:0] req, input logic [31:0] dly,
                            input logic [15:0] id);
        request_t e;
        // random idle burst ahead of the item, never in the tail
        if (tx_gaps_on && n_items < ITEMS - TAIL && $urandom_range(0, 3) == 0) begin
            e.kind    = ENTRY_GAP;
            e.gap_len = $urandom_range(1, 11);
            pending.push_back(e);
        end
        e.kind    = ENTRY_ITEM;
        e.req     = req;
        e.delay   = dly;
        e.tag     = id;
        e.gap_len = 0;
        pending.push_back(e);
        // ignored requests do not count towards the volume
        if (req != REQ_SPARE) n_items++;
    endtask

    task automatic add_drain();
        request_t e;
        e.kind    = ENTRY_DRAIN;
        e.req     = REQ_SPARE;
        e.delay   = '0;
        e.tag     = '0;
        e.gap_len = 0;
        pending.push_back(e);
    endtask

    // Mostly short delays so events come due; now and then a full-width one
    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)  return $urandom();
        if (r < 12) return $urandom_range(0, 60);
        return $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------
    // Sender: one entry of the pending queue per free cycle
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : request_drive
        request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else if (!s_valid || s_ready) begin
            if (tx_gap != 0) begin
                tx_gap  <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pending.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending[0].kind == ENTRY_DRAIN) begin
                // hold off until the block has answered everything; s_valid low
                // last cycle means no item went in at this edge
                s_valid <= 1'b0;
                if (!s_valid && in_flight == 0) pending.delete(0);
            end else if (pending[0].kind == ENTRY_GAP) begin
                nxt     = pending.pop_front();
                tx_gap  <= nxt.gap_len - 1;
                s_valid <= 1'b0;
            end else begin
                nxt        = pending.pop_front();
                s_valid    <= 1'b1;
                s_req_type <= nxt.req;
                s_delay    <= nxt.delay;
                s_tag      <= nxt.tag;
            end
        end
        tx_done   <= (pending.size() == 0);
        tail_part <= (pending.size() < TAIL);
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, quiet stretches, and one long hold
    // that lets the block back up into its input
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_accept
        int unsigned r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN - 1;
            m_ready   <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap  <= rx_gap - 1;
            m_ready <= 1'b0;
        end else if (rx_quiet != 0 || tail_part) begin
            if (rx_quiet != 0) rx_quiet <= rx_quiet - 1;
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 15);
            if (r < 3) begin
                rx_gap  <= $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else if (r == 3) begin
                rx_quiet <= $urandom_range(20, 80);
                m_ready  <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted item, checks each result item
    // against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        result_t want;
        if (!aresetn) begin
            in_flight  <= 0;
            n_accepted <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(event_table_step(s_req_type, s_delay, s_tag));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, status %0d tag %h",
                             $time, m_status, m_fired_tag);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_status);
                        errors++;
                    end
                    if (m_fired_tag !== want.fired_tag) begin
                        $display("%0t: fired_tag expected %h, got %h",
                                 $time, want.fired_tag, m_fired_tag);
                        errors++;
                    end
                end
            end
            in_flight  <= in_flight + int'(s_valid && s_ready) - int'(m_valid && m_ready);
            n_accepted <= n_accepted + int'(s_valid && s_ready);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build, reset, and end of run
    // ------------------------------------------------------------------
    initial begin : run_control
        int  phase;
        int  len;
        int  r;
        bit  mid_drain_done;
        mid_drain_done = 1'b0;

        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            slot_due[i]  = '0;
            slot_id[i]   = '0;
        end
        now_ms = '0;

        // Directed opening
        add_item(REQ_DISPATCH, '0, '0);                    // empty table
        add_item(REQ_SPARE, 32'hFFFF_FFFF, 16'hFFFF);      // unused code
        add_item(REQ_POST, 32'd0, 16'hFFFF);
        add_item(REQ_POST, 32'd0, 16'h0000);               // same due time
        add_item(REQ_DISPATCH, '0, '0);                    // tie, lower slot fires
        add_item(REQ_DISPATCH, '0, '0);
        add_item(REQ_POST, 32'd2, 16'hA5A5);
        add_item(REQ_DISPATCH, '0, '0);                    // not yet due
        add_item(REQ_TICK, '0, '0);
        add_item(REQ_DISPATCH, '0, '0);
        add_item(REQ_TICK, '0, '0);
        add_item(REQ_DISPATCH, '0, '0);                    // due exactly now
        add_item(REQ_POST, 32'hFFFF_FFFF, 16'h5A5A);       // due time saturates
        add_item(REQ_POST, 32'hFFFF_FFFD, 16'h0001);       // lands on the top value
        add_item(REQ_POST, 32'h8000_0000, 16'h0002);
        add_item(REQ_DISPATCH, '0, '0);                    // table busy, none due
        add_item(REQ_POST, 32'd1, 16'h0003);
        add_item(REQ_POST, 32'd0, 16'h0004);               // earlier due in a higher slot
        add_item(REQ_DISPATCH, '0, '0);
        add_item(REQ_DISPATCH, '0, '0);
        add_item(REQ_TICK, '0, '0);
        add_item(REQ_DISPATCH, '0, '0);
        add_drain();

        // Random part, built from phases
        while (n_items < ITEMS) begin
            if (!mid_drain_done && n_items >= 400) begin
                add_drain();
                mid_drain_done = 1'b1;
            end
            tx_gaps_on = ($urandom_range(0, 2) != 0);
            phase = $urandom_range(0, 9);
            if (phase <= 5) begin
                // general mix
                len = $urandom_range(20, 40);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 35)      add_item(REQ_POST, pick_delay(), 16'($urandom()));
                    else if (r < 65) add_item(REQ_TICK, $urandom(), 16'($urandom()));
                    else if (r < 95) add_item(REQ_DISPATCH, $urandom(), 16'($urandom()));
                    else             add_item(REQ_SPARE, $urandom(), 16'($urandom()));
                end
            end else if (phase == 6) begin
                // fill past capacity, then drain with the odd tick
                for (int k = 0; k < NUM_SLOTS + 2; k++)
                    add_item(REQ_POST, $urandom_range(0, 3), 16'($urandom()));
                for (int k = 0; k < NUM_SLOTS + 8; k++) begin
                    if (k % 8 == 0) add_item(REQ_TICK, '0, '0);
                    else            add_item(REQ_DISPATCH, '0, '0);
                end
            end else if (phase == 7) begin
                // time jump, then collect what came due
                len = $urandom_range(5, 30);
                for (int k = 0; k < len; k++) add_item(REQ_TICK, '0, '0);
                for (int k = 0; k < 6; k++)   add_item(REQ_DISPATCH, '0, '0);
            end else begin
                // post and fire straight away, tags churning through slots
                len = $urandom_range(5, 15);
                for (int k = 0; k < len; k++) begin
                    add_item(REQ_POST, $urandom_range(0, 1), 16'($urandom()));
                    add_item(REQ_DISPATCH, '0, '0);
                end
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // all sent, all answered, then a margin for any stray result
        while (!(tx_done && !s_valid && in_flight == 0)) @(posedge aclk);
        repeat (NUM_SLOTS + 8) @(posedge aclk);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/teq_pkg.sv
rtl/teq_cell.sv
rtl/timed_event_queue_top.sv
verif/timed_event_queue_top_tb.sv
